### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/dwo_pkg.sv
// ---------------------------------------------------------------------------
// dwo_pkg
// field widths, item kind codes and reset constants of the drawn oscillator
// ---------------------------------------------------------------------------
`default_nettype none

package dwo_pkg;

	localparam int KIND_W  = 2;
	localparam int INDEX_W = 11;
	localparam int VALUE_W = 16;
	localparam int STEP_W  = 27;

	localparam logic [KIND_W-1:0] KIND_PEN_DOWN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PEN_UP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

	// phase step after reset, before any saturation to the table depth
	localparam logic [STEP_W-1:0] STEP_RESET = 27'd1339134;

endpackage

`default_nettype wire

### hw/rtl/drawn_wavetable_oscillator.sv
// ---------------------------------------------------------------------------
// drawn_wavetable_oscillator
// wavetable oscillator whose table is drawn with pen strokes and linear fill
// ---------------------------------------------------------------------------
// tick: table read into rd_data_q, then ST_TICK loads sample_out when free;
//   further items wait in ST_TICK until the result register takes the sample
// pen up, plain pen down, unused kind: handled in ST_IDLE; stroke from a held point:
//   ST_DIV divides |value diff| by |index diff|, then ST_FILL writes the span
// reset: asynchronous, then a clearing pass (ST_CLEAR) zeroes the table;
//   items wait meanwhile, configuration beats are taken always
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module drawn_wavetable_oscillator #(
	parameter int TABLE_DEPTH         = 2048,
	parameter int PHASE_FRACTION_BITS = 16,
	parameter int SAMPLE_WIDTH        = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel: phase step
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dwo_pkg::STEP_W-1:0]        cfg_data,
	// input item channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [dwo_pkg::KIND_W-1:0]        kind,
	input  wire logic [dwo_pkg::INDEX_W-1:0]       draw_index,
	input  wire logic signed [dwo_pkg::VALUE_W-1:0] draw_value,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [dwo_pkg::VALUE_W-1:0]     sample_out
);

	// table index width, phase width
	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FB  = PHASE_FRACTION_BITS;
	localparam int SW  = SAMPLE_WIDTH;
	localparam int PW  = IW + FB;
	// magnitude of a sample difference, also the divider's dividend width
	localparam int NW  = SW + 1;
	localparam int CNTW = $clog2(NW + 1);
	// compare widths for saturating the index and the step
	localparam int IXW  = (IW + 1 > dwo_pkg::INDEX_W) ? IW + 1 : dwo_pkg::INDEX_W;
	localparam int CMPW = (PW + 1 > dwo_pkg::STEP_W) ? PW + 1 : dwo_pkg::STEP_W;

	localparam logic [PW:0]   PHASE_LIMIT = (PW + 1)'(TABLE_DEPTH) << FB;
	localparam logic [PW:0]   STEP_MAX_W  = PHASE_LIMIT - (PW + 1)'(1);
	localparam logic [PW-1:0] STEP_MAX    = STEP_MAX_W[PW-1:0];
	localparam logic [CMPW-1:0] STEP_RESET_X = CMPW'(dwo_pkg::STEP_RESET);
	localparam logic [CMPW-1:0] LIMIT_X      = CMPW'(PHASE_LIMIT);
	localparam logic [PW-1:0] STEP_INIT =
		(STEP_RESET_X >= LIMIT_X) ? STEP_MAX : STEP_RESET_X[PW-1:0];
	localparam logic [IW-1:0] LAST_INDEX = IW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_FILL,
		ST_TICK
	} state_t;

	state_t state_q;

	// configuration: phase step, saturated below the table depth
	logic [PW-1:0]   step_q;
	logic [CMPW-1:0] cfg_x;

	assign cfg_ready = 1'b1;
	assign cfg_x     = CMPW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_INIT;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_x >= LIMIT_X) begin
				step_q <= STEP_MAX;
			end else begin
				step_q <= cfg_x[PW-1:0];
			end
		end
	end

	// oscillator and pen state
	logic [PW-1:0] phase_q;
	logic [IW-1:0] held_index_q;
	logic [SW-1:0] held_value_q;
	logic          held_valid_q;

	// clearing pass address
	logic [IW-1:0] clr_cnt_q;

	// stroke registers: divider, fill walk and interpolation accumulators
	logic [IW-1:0]   abs_di_q;
	logic [NW-1:0]   div_n_q;    // dividend in, quotient out
	logic [IW-1:0]   div_r_q;    // remainder
	logic [CNTW-1:0] div_cnt_q;
	logic [IW-1:0]   fill_pos_q;
	logic [IW-1:0]   end_idx_q;
	logic            dir_up_q;
	logic            neg_dv_q;
	logic [SW-1:0]   base_q;
	logic [NW-1:0]   acc_q_q;
	logic [IW-1:0]   acc_r_q;

	// result register
	logic                        out_valid_q;
	logic [dwo_pkg::VALUE_W-1:0] sample_q;

	// table memory
	logic [SW-1:0] wave_table_q [TABLE_DEPTH];
	logic [SW-1:0] rd_data_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;

	// input beat decode
	logic                 in_fire;
	logic [IXW-1:0]       draw_x;
	logic [IW-1:0]        idx_sat;
	logic [SW+15:0]       val_raw;
	logic [SW-1:0]        val_in;
	logic signed [IW:0]   di;
	logic signed [IW:0]   neg_di;
	logic [IW-1:0]        abs_di;
	logic signed [SW:0]   dv;
	logic signed [SW:0]   neg_dv;
	logic [NW-1:0]        abs_dv;
	logic                 interp;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign draw_x  = IXW'(draw_index);
	assign idx_sat = (draw_x >= IXW'(TABLE_DEPTH)) ? LAST_INDEX : draw_x[IW-1:0];

	// raw 16-bit value, taken at the sample width (sign from bit SW-1)
	assign val_raw = {{SW{1'b0}}, draw_value};
	assign val_in  = val_raw[SW-1:0];

	assign di     = $signed({1'b0, idx_sat}) - $signed({1'b0, held_index_q});
	assign neg_di = -di;
	assign abs_di = di[IW] ? neg_di[IW-1:0] : di[IW-1:0];
	assign dv     = $signed({val_in[SW-1], val_in})
	              - $signed({held_value_q[SW-1], held_value_q});
	assign neg_dv = -dv;
	assign abs_dv = dv[SW] ? neg_dv : dv;
	assign interp = held_valid_q && (idx_sat != held_index_q);

	// shared compare and subtract against the index difference:
	// restoring division steps, then remainder carry during the fill
	logic [IW:0] cs_a;
	logic [IW:0] cs_b;
	logic [IW:0] cs_diff;
	logic        cs_ge;
	logic [IW-1:0] cs_res;

	always_comb begin
		cs_a = '0;
		case (state_q)
			ST_DIV:  cs_a = {div_r_q, div_n_q[NW-1]};
			ST_FILL: cs_a = {1'b0, acc_r_q} + {1'b0, div_r_q};
			default: cs_a = '0;
		endcase
	end

	assign cs_b    = {1'b0, abs_di_q};
	assign cs_ge   = (cs_a >= cs_b);
	assign cs_diff = cs_a - cs_b;
	assign cs_res  = cs_ge ? cs_diff[IW-1:0] : cs_a[IW-1:0];

	// interpolated entry: base +/- accumulated quotient, always between ends
	logic signed [SW+1:0] base_x;
	logic signed [SW+1:0] q_x;
	logic signed [SW+1:0] fill_val;

	assign base_x   = {{2{base_q[SW-1]}}, base_q};
	assign q_x      = {1'b0, acc_q_q};
	assign fill_val = neg_dv_q ? (base_x - q_x) : (base_x + q_x);

	// table write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				// single point write when no stroke is started
				if (in_fire && (kind == dwo_pkg::KIND_PEN_DOWN) && !interp) begin
					mem_we    = 1'b1;
					mem_waddr = idx_sat;
					mem_wdata = val_in;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_pos_q;
				mem_wdata = fill_val[SW-1:0];
			end
			default: mem_we = 1'b0;
		endcase
	end

	// table read port: integer part of the phase, on a tick beat
	assign mem_re    = in_fire && (kind == dwo_pkg::KIND_TICK);
	assign mem_raddr = phase_q[PW-1:FB];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wave_table_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= wave_table_q[mem_raddr];
		end
	end

	// phase advance with one wrap by the table depth
	logic [PW:0] phase_sum;
	logic [PW:0] phase_wrap;
	logic [PW-1:0] phase_next;

	assign phase_sum  = {1'b0, phase_q} + {1'b0, step_q};
	assign phase_wrap = phase_sum - PHASE_LIMIT;
	assign phase_next = (phase_sum >= PHASE_LIMIT) ? phase_wrap[PW-1:0] : phase_sum[PW-1:0];

	// sample read, raw sample bits zero extended to the output field
	logic [dwo_pkg::VALUE_W+SW-1:0] rd_x;
	assign rd_x = {{dwo_pkg::VALUE_W{1'b0}}, rd_data_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			phase_q      <= '0;
			held_index_q <= '0;
			held_value_q <= '0;
			held_valid_q <= 1'b0;
			clr_cnt_q    <= '0;
			abs_di_q     <= '0;
			div_n_q      <= '0;
			div_r_q      <= '0;
			div_cnt_q    <= '0;
			fill_pos_q   <= '0;
			end_idx_q    <= '0;
			dir_up_q     <= 1'b0;
			neg_dv_q     <= 1'b0;
			base_q       <= '0;
			acc_q_q      <= '0;
			acc_r_q      <= '0;
			out_valid_q  <= 1'b0;
			sample_q     <= '0;
		end else begin
			// result beat taken downstream; a waiting tick reloads it below
			if (out_valid_q && out_ready && (state_q != ST_TICK)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IW'(1);
					if (clr_cnt_q == LAST_INDEX) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (in_fire) begin
						case (kind)
							dwo_pkg::KIND_PEN_DOWN: begin
								if (interp) begin
									// start a stroke from the held point
									abs_di_q   <= abs_di;
									div_n_q    <= abs_dv;
									div_r_q    <= '0;
									div_cnt_q  <= CNTW'(NW);
									fill_pos_q <= held_index_q;
									end_idx_q  <= idx_sat;
									dir_up_q   <= !di[IW];
									neg_dv_q   <= dv[SW];
									base_q     <= held_value_q;
									acc_q_q    <= '0;
									acc_r_q    <= '0;
									state_q    <= ST_DIV;
								end
								held_index_q <= idx_sat;
								held_value_q <= val_in;
								held_valid_q <= 1'b1;
							end
							dwo_pkg::KIND_PEN_UP: begin
								held_valid_q <= 1'b0;
							end
							dwo_pkg::KIND_TICK: begin
								phase_q <= phase_next;
								state_q <= ST_TICK;
							end
							default: begin
								// unused kind: no effect
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				ST_DIV: begin
					// one quotient bit per cycle
					div_r_q   <= cs_res;
					div_n_q   <= {div_n_q[NW-2:0], cs_ge};
					div_cnt_q <= div_cnt_q - CNTW'(1);
					if (div_cnt_q == CNTW'(1)) begin
						state_q <= ST_FILL;
					end
				end

				ST_FILL: begin
					// one table entry per cycle, quotient and remainder stepped
					acc_r_q <= cs_res;
					acc_q_q <= acc_q_q + div_n_q + NW'(cs_ge);
					if (fill_pos_q == end_idx_q) begin
						state_q <= ST_IDLE;
					end else if (dir_up_q) begin
						fill_pos_q <= fill_pos_q + IW'(1);
					end else begin
						fill_pos_q <= fill_pos_q - IW'(1);
					end
				end

				ST_TICK: begin
					// load the result register once it is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						sample_q    <= rd_x[dwo_pkg::VALUE_W-1:0];
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	// fill only ever follows the divider or itself
	`ASSERT_SAME(a_fill_entry, clk, arst_n, (state_q == ST_FILL),
		($past(state_q) == ST_DIV) || ($past(state_q) == ST_FILL))
	// the carried remainder stays below the index difference during a fill
	`ASSERT_SAME(a_fill_rem, clk, arst_n, (state_q == ST_FILL), (acc_r_q < abs_di_q))
	// a tick that finds the result register free shows its sample next cycle
	`ASSERT_NEXT(a_tick_out, clk, arst_n,
		(state_q == ST_TICK) && (!out_valid_q || out_ready), out_valid)
	// no table write while a tick waits on the output
	`ASSERT_SAME(a_tick_nowrite, clk, arst_n, (state_q == ST_TICK), !mem_we)

endmodule

`default_nettype wire
